// ----- sv/apbc_pkg.sv -----
// apbc_pkg: element codes, lane and merge result types, valence and bond tables
// for the atom pair bond cutoff block. No dependencies.
`timescale 1ns / 1ps
package apbc_pkg;

   localparam int NAME_CHARS = 4;
   localparam int EL_W       = 5;
   localparam int VAL_W      = 4;
   localparam int CUT_W      = 8;

   localparam logic [EL_W-1:0] EL_UNKNOWN = 5'd0;
   localparam logic [EL_W-1:0] EL_H  = 5'd1;
   localparam logic [EL_W-1:0] EL_B  = 5'd2;
   localparam logic [EL_W-1:0] EL_C  = 5'd3;
   localparam logic [EL_W-1:0] EL_N  = 5'd4;
   localparam logic [EL_W-1:0] EL_O  = 5'd5;
   localparam logic [EL_W-1:0] EL_F  = 5'd6;
   localparam logic [EL_W-1:0] EL_P  = 5'd7;
   localparam logic [EL_W-1:0] EL_S  = 5'd8;
   localparam logic [EL_W-1:0] EL_CL = 5'd9;
   localparam logic [EL_W-1:0] EL_BR = 5'd10;
   localparam logic [EL_W-1:0] EL_FE = 5'd11;
   localparam logic [EL_W-1:0] EL_CA = 5'd12;
   localparam logic [EL_W-1:0] EL_I  = 5'd13;
   localparam logic [EL_W-1:0] EL_MG = 5'd14;
   localparam logic [EL_W-1:0] EL_CU = 5'd15;
   localparam logic [EL_W-1:0] EL_LI = 5'd16;
   localparam logic [EL_W-1:0] EL_K  = 5'd17;
   localparam logic [EL_W-1:0] EL_RB = 5'd18;
   localparam logic [EL_W-1:0] EL_CS = 5'd19;
   localparam logic [EL_W-1:0] EL_ZN = 5'd20;
   localparam logic [EL_W-1:0] EL_NA = 5'd21;

   localparam logic [CUT_W-1:0] DEFAULT_CUT = 8'd160;
   localparam logic [CUT_W-1:0] PAD_CUT     = 8'd10;

   localparam logic [VAL_W-1:0] DEFAULT_VALENCE_RESET = 4'd8;

   typedef struct packed {
      logic [EL_W-1:0]  element;
      logic             ion;
      logic [VAL_W-1:0] valence;
   } lane_result_type;

   typedef struct packed {
      logic [CUT_W-1:0] cutoff;
      logic             known;
      logic             ion;
   } merge_result_type;

   // listed valence, 0 where none is listed
   function automatic logic [VAL_W-1:0] listed_valence(input logic [EL_W-1:0] el);
      logic [VAL_W-1:0] v;
      case (el)
         EL_H:    v = 4'd1;
         EL_B:    v = 4'd3;
         EL_C:    v = 4'd4;
         EL_N:    v = 4'd4;
         EL_O:    v = 4'd2;
         EL_F:    v = 4'd1;
         EL_P:    v = 4'd5;
         EL_S:    v = 4'd6;
         EL_CL:   v = 4'd1;
         EL_BR:   v = 4'd1;
         default: v = 4'd0;
      endcase
      return v;
   endfunction

   // {known, length in centi-angstrom} for an ordered pair lo <= hi
   function automatic logic [CUT_W:0] pair_length(input logic [EL_W-1:0] lo,
                                                  input logic [EL_W-1:0] hi);
      logic [CUT_W:0] r;
      case ({lo, hi})
         {EL_H,  EL_H }: r = {1'b1, 8'd74};
         {EL_N,  EL_N }: r = {1'b1, 8'd145};
         {EL_C,  EL_C }: r = {1'b1, 8'd154};
         {EL_O,  EL_O }: r = {1'b1, 8'd148};
         {EL_P,  EL_P }: r = {1'b1, 8'd221};
         {EL_S,  EL_S }: r = {1'b1, 8'd205};
         {EL_H,  EL_C }: r = {1'b1, 8'd109};
         {EL_H,  EL_N }: r = {1'b1, 8'd101};
         {EL_H,  EL_O }: r = {1'b1, 8'd96};
         {EL_H,  EL_P }: r = {1'b1, 8'd144};
         {EL_H,  EL_S }: r = {1'b1, 8'd134};
         {EL_C,  EL_N }: r = {1'b1, 8'd147};
         {EL_C,  EL_O }: r = {1'b1, 8'd143};
         {EL_C,  EL_P }: r = {1'b1, 8'd184};
         {EL_C,  EL_F }: r = {1'b1, 8'd135};
         {EL_C,  EL_CL}: r = {1'b1, 8'd177};
         {EL_C,  EL_BR}: r = {1'b1, 8'd194};
         {EL_C,  EL_S }: r = {1'b1, 8'd182};
         {EL_N,  EL_O }: r = {1'b1, 8'd140};
         {EL_N,  EL_S }: r = {1'b1, 8'd168};
         {EL_N,  EL_F }: r = {1'b1, 8'd136};
         {EL_N,  EL_CL}: r = {1'b1, 8'd175};
         {EL_N,  EL_P }: r = {1'b1, 8'd171};
         {EL_O,  EL_P }: r = {1'b1, 8'd163};
         {EL_P,  EL_S }: r = {1'b1, 8'd186};
         {EL_F,  EL_P }: r = {1'b1, 8'd154};
         {EL_P,  EL_CL}: r = {1'b1, 8'd203};
         {EL_O,  EL_S }: r = {1'b1, 8'd148};
         {EL_O,  EL_F }: r = {1'b1, 8'd142};
         {EL_F,  EL_S }: r = {1'b1, 8'd156};
         {EL_S,  EL_CL}: r = {1'b1, 8'd207};
         default:        r = {1'b0, DEFAULT_CUT};
      endcase
      return r;
   endfunction

endpackage

// ----- sv/apbc_name_lane.sv -----
// apbc_name_lane: decodes one atom name into element code, ion flag and valence.
// Depends on apbc_pkg.
`timescale 1ns / 1ps
module apbc_name_lane
   import apbc_pkg::*;
(
   input  logic [7:0]       name_chars [NAME_CHARS],
   input  logic [VAL_W-1:0] default_valence,
   output lane_result_type  result
);

   localparam int POS_W = $clog2(NAME_CHARS);

   logic             found;
   logic [POS_W-1:0] pos;
   logic [7:0]       c0;
   logic [7:0]       c1;
   logic             alive;
   logic             ion;
   logic [EL_W-1:0]  el;
   logic [VAL_W-1:0] listed;

   // first byte that is neither a space nor past the end of the name
   always_comb begin
      found = 1'b0;
      pos   = '0;
      alive = 1'b1;
      for (int i = 0; i < NAME_CHARS; i++) begin
         if (name_chars[i] == 8'h00) alive = 1'b0;
         if (alive && !found && name_chars[i] != " ") begin
            found = 1'b1;
            pos   = POS_W'(i);
         end
      end
   end

   always_comb begin
      c0 = name_chars[pos];
      c1 = 8'h00;
      if ({1'b0, pos} < (POS_W+1)'(NAME_CHARS - 1)) c1 = name_chars[pos + POS_W'(1)];
   end

   always_comb begin
      el = EL_UNKNOWN;
      if (found) begin
         case (c0)
            "H": el = EL_H;
            "C": begin
               if (c1 == "l" || c1 == "L") el = EL_CL;
               else if (c1 == "0")         el = EL_CA;
               else if (c1 == "s")         el = EL_CS;
               else if (c1 == "U")         el = EL_CU;
               else                        el = EL_C;
            end
            "N": el = (c1 == "a") ? EL_NA : EL_N;
            "O": el = EL_O;
            "F": el = (c1 == "e" || c1 == "E") ? EL_FE : EL_F;
            "B": el = (c1 == "r" || c1 == "R") ? EL_BR : EL_B;
            "I": begin
               if (c1 == "M")      el = EL_CL;
               else if (c1 == "P") el = EL_NA;
               else                el = EL_I;
            end
            "P": el = EL_P;
            "S": el = EL_S;
            "M": el = (c1 == "G") ? EL_MG : EL_UNKNOWN;
            "Z": el = (c1 == "n") ? EL_ZN : EL_UNKNOWN;
            "L": el = (c1 == "i") ? EL_LI : EL_UNKNOWN;
            "K": el = EL_K;
            "R": el = (c1 == "b") ? EL_RB : EL_UNKNOWN;
            default: el = EL_UNKNOWN;
         endcase
      end
   end

   // charge sign anywhere from byte 1 up to the end of the name
   always_comb begin
      logic live;
      live = (name_chars[0] != 8'h00);
      ion  = 1'b0;
      for (int i = 1; i < NAME_CHARS; i++) begin
         if (name_chars[i] == 8'h00) live = 1'b0;
         if (live && (name_chars[i] == "+" || name_chars[i] == "-")) ion = 1'b1;
      end
   end

   assign listed         = listed_valence(el);
   assign result.element = el;
   assign result.ion     = ion;
   assign result.valence = (listed != '0) ? listed : default_valence;

endmodule

// ----- sv/apbc_pair_merge.sv -----
// apbc_pair_merge: combines the two lane results into the padded bond cutoff.
// Depends on apbc_pkg.
`timescale 1ns / 1ps
module apbc_pair_merge
   import apbc_pkg::*;
(
   input  lane_result_type  lane_a,
   input  lane_result_type  lane_b,
   output merge_result_type merged
);

   logic [EL_W-1:0] lo;
   logic [EL_W-1:0] hi;
   logic [CUT_W:0]  entry;
   logic            ion;

   assign lo    = (lane_a.element < lane_b.element) ? lane_a.element : lane_b.element;
   assign hi    = (lane_a.element < lane_b.element) ? lane_b.element : lane_a.element;
   assign entry = pair_length(lo, hi);
   assign ion   = lane_a.ion | lane_b.ion;

   assign merged.known  = entry[CUT_W];
   assign merged.ion    = ion;
   assign merged.cutoff = ion ? '0 : entry[CUT_W-1:0] + PAD_CUT;

endmodule

// ----- sv/atom_pair_bond_cutoff.sv -----
// atom_pair_bond_cutoff: top level, two name lanes, lane register, pair merge,
// output register and APB-style register port. Depends on apbc_pkg, apbc_name_lane,
// apbc_pair_merge.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  name_a_char0..3, name_b_char0..3
//   rsp_      out        rsp_valid/rsp_stall  element_a/b, cutoff_centi, pair_known,
//                                             ion_found, valence_a/b
//   csr_      in/out     psel/penable/pready  default_valence at address 0
//
// Accepted items pass through the lane register, then the output register.
// One item per cycle while rsp_stall is low; the lanes and merge are combinational.
// Synchronous reset empties both stages and sets default_valence to 8.
// A stalled result holds the output register; the lane stage fills behind it and
// req_stall rises only when both stages are full and rsp_stall is high.
`timescale 1ns / 1ps
module atom_pair_bond_cutoff
   import apbc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,

   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_name_a_char0,
   input  logic [7:0]       req_name_a_char1,
   input  logic [7:0]       req_name_a_char2,
   input  logic [7:0]       req_name_a_char3,
   input  logic [7:0]       req_name_b_char0,
   input  logic [7:0]       req_name_b_char1,
   input  logic [7:0]       req_name_b_char2,
   input  logic [7:0]       req_name_b_char3,

   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [EL_W-1:0]  rsp_element_a,
   output logic [EL_W-1:0]  rsp_element_b,
   output logic [CUT_W-1:0] rsp_cutoff_centi,
   output logic             rsp_pair_known,
   output logic             rsp_ion_found,
   output logic [VAL_W-1:0] rsp_valence_a,
   output logic [VAL_W-1:0] rsp_valence_b,

   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam logic CSR_DEFAULT_VALENCE = 1'b0;

   logic [VAL_W-1:0] default_valence_ff;
   logic [VAL_W-1:0] default_valence_in;
   logic             csr_write;

   logic [7:0]       name_a [NAME_CHARS];
   logic [7:0]       name_b [NAME_CHARS];
   lane_result_type  lane_a;
   lane_result_type  lane_b;

   logic             s1_valid_ff;
   logic             s1_valid_in;
   lane_result_type  s1_a_ff;
   lane_result_type  s1_b_ff;
   merge_result_type merged;

   logic             out_valid_ff;
   logic             out_valid_in;
   logic             out_adv;
   logic             s1_adv;
   logic             req_take;

   logic [EL_W-1:0]  out_el_a_ff;
   logic [EL_W-1:0]  out_el_b_ff;
   logic [CUT_W-1:0] out_cut_ff;
   logic             out_known_ff;
   logic             out_ion_ff;
   logic [VAL_W-1:0] out_val_a_ff;
   logic [VAL_W-1:0] out_val_b_ff;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready
                     & (csr_paddr[2] == CSR_DEFAULT_VALENCE);
   assign default_valence_in = csr_write ? csr_pwdata[VAL_W-1:0] : default_valence_ff;
   assign csr_prdata = (csr_paddr[2] == CSR_DEFAULT_VALENCE)
                     ? {{(32-VAL_W){1'b0}}, default_valence_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_valence_ff <= DEFAULT_VALENCE_RESET;
      end else begin
         default_valence_ff <= default_valence_in;
      end
   end

   // lanes
   assign name_a[0] = req_name_a_char0;
   assign name_a[1] = req_name_a_char1;
   assign name_a[2] = req_name_a_char2;
   assign name_a[3] = req_name_a_char3;
   assign name_b[0] = req_name_b_char0;
   assign name_b[1] = req_name_b_char1;
   assign name_b[2] = req_name_b_char2;
   assign name_b[3] = req_name_b_char3;

   apbc_name_lane u_lane_a (
      .name_chars      (name_a),
      .default_valence (default_valence_ff),
      .result          (lane_a)
   );

   apbc_name_lane u_lane_b (
      .name_chars      (name_b),
      .default_valence (default_valence_ff),
      .result          (lane_b)
   );

   // pipeline control
   assign out_adv   = !out_valid_ff || !rsp_stall;
   assign s1_adv    = !s1_valid_ff || out_adv;
   assign req_stall = !s1_adv;
   assign req_take  = req_valid && s1_adv;

   assign s1_valid_in  = s1_adv ? req_valid : s1_valid_ff;
   assign out_valid_in = out_adv ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_a_ff <= lane_a;
         s1_b_ff <= lane_b;
      end
   end

   apbc_pair_merge u_merge (
      .lane_a (s1_a_ff),
      .lane_b (s1_b_ff),
      .merged (merged)
   );

   always_ff @(posedge clock) begin
      if (out_adv && s1_valid_ff) begin
         out_el_a_ff  <= s1_a_ff.element;
         out_el_b_ff  <= s1_b_ff.element;
         out_cut_ff   <= merged.cutoff;
         out_known_ff <= merged.known;
         out_ion_ff   <= merged.ion;
         out_val_a_ff <= s1_a_ff.valence;
         out_val_b_ff <= s1_b_ff.valence;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_element_a    = out_el_a_ff;
   assign rsp_element_b    = out_el_b_ff;
   assign rsp_cutoff_centi = out_cut_ff;
   assign rsp_pair_known   = out_known_ff;
   assign rsp_ion_found    = out_ion_ff;
   assign rsp_valence_a    = out_val_a_ff;
   assign rsp_valence_b    = out_val_b_ff;

   // checks
   a_ion_zero_cut: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ion_found |-> rsp_cutoff_centi == '0)
      else $error("ion item with non-zero cutoff");

   a_unknown_cut: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ion_found && !rsp_pair_known
         |-> rsp_cutoff_centi == DEFAULT_CUT + PAD_CUT)
      else $error("unlisted pair without default cutoff");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid && rsp_stall)
      else $error("input stalled while pipeline can advance");

   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted item lost from lane stage");

endmodule
